FILE: sv/assert_macros.svh
// Assertion macros used by the datapath RTL of the region merge engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is never true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: sv/wrm_pkg.sv
// Types, constants and step codes of the watershed region merge engine.
package wrm_pkg;

   localparam int LABEL_BITS = 10;
   localparam int NODE_BITS  = 11;
   localparam int CNT_BITS   = 12;
   localparam int AREA_BITS  = 20;
   localparam int REG_BITS   = 10;
   localparam int MAX_LABELS = 1 << LABEL_BITS;
   localparam int MAX_NODES  = 1 << NODE_BITS;

   localparam logic [AREA_BITS-1:0] AREA_MAX   = '1;
   localparam logic [REG_BITS-1:0]  REGION_MAX = '1;
   localparam logic [CNT_BITS-1:0]  NO_PARENT  = CNT_BITS'(MAX_NODES);

   // Configuration register indexes.
   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_MIN_AREA  = 1'b1;
   localparam int   CSR_BITS      = 20;

   // Actions.
   localparam logic [1:0] ACT_PIXEL  = 2'd0;
   localparam logic [1:0] ACT_EDGE   = 2'd1;
   localparam logic [1:0] ACT_FINISH = 2'd2;
   localparam logic [1:0] ACT_LOOKUP = 2'd3;

   // Controller steps, also the datapath command code.
   localparam int         STEP_BITS = 5;
   localparam logic [4:0] ST_CLR   = 5'd0;
   localparam logic [4:0] ST_IDLE  = 5'd1;
   localparam logic [4:0] ST_LA    = 5'd2;
   localparam logic [4:0] ST_PIX1  = 5'd3;
   localparam logic [4:0] ST_PIX2  = 5'd4;
   localparam logic [4:0] ST_EA1   = 5'd5;
   localparam logic [4:0] ST_WALKA = 5'd6;
   localparam logic [4:0] ST_EB1   = 5'd7;
   localparam logic [4:0] ST_WALKB = 5'd8;
   localparam logic [4:0] ST_M1    = 5'd9;
   localparam logic [4:0] ST_M2    = 5'd10;
   localparam logic [4:0] ST_F0    = 5'd11;
   localparam logic [4:0] ST_F1    = 5'd12;
   localparam logic [4:0] ST_L1    = 5'd13;
   localparam logic [4:0] ST_WALKL = 5'd14;
   localparam logic [4:0] ST_RESP  = 5'd15;

   typedef struct packed {
      logic [1:0]            action;
      logic [LABEL_BITS-1:0] label_a;
      logic [LABEL_BITS-1:0] label_b;
      logic signed [15:0]    strength;
   } req_type;

   typedef struct packed {
      logic                  merged;
      logic [NODE_BITS-1:0]  new_node;
      logic [REG_BITS-1:0]   region_number;
      logic [REG_BITS-1:0]   region_total;
   } rsp_type;

   typedef struct packed {
      logic [STEP_BITS-1:0] op;
      logic                 accept;
      logic                 load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       la_zero;
      logic       lb_zero;
      logic       lab_zero;
      logic       walk_more;
      logic       no_merge;
      logic       nc_zero;
      logic       scan_last;
      logic       clr_last;
      logic       out_free;
   } status_type;

endpackage

FILE: sv/watershed_region_merge_min_area.sv
// Top level of the watershed region merge engine with a minimum area rule.
//
// Input transfers on req_ carry an action: pixel, edge, finish or lookup.
// Edge, finish and lookup items each give one result transfer on rsp_;
// pixel items give none. Items are worked one at a time.
// An edge walks from both labels' leaves up to their roots, then may merge
// the two roots; a lookup walks one leaf to its root; finish scans all
// nodes. A boundary or unknown label ends an edge or a lookup early. The
// walks and the finish scan each take one node store read a cycle.
// After reset the label area store is cleared, one entry a cycle, all
// 1024 entries; req_stall is high meanwhile and configuration writes
// through csr_ are taken as ever.
// A result waits in an output register; the next item is accepted while it
// waits, and a later result holds in the engine until the receiver drops
// rsp_stall.
module watershed_region_merge_min_area (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  wrm_pkg::req_type             req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output wrm_pkg::rsp_type             rsp_payload,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [wrm_pkg::CSR_BITS-1:0] csr_wdata
);

   wrm_pkg::cmd_type    cmd;
   wrm_pkg::status_type status;

   // Controller.
   wrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   wrm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: sv/wrm_ctrl.sv
// Controller state machine of the watershed region merge engine.
module wrm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  wrm_pkg::status_type status,
   output wrm_pkg::cmd_type    cmd
);

   logic [wrm_pkg::STEP_BITS-1:0] state_ff;
   logic [wrm_pkg::STEP_BITS-1:0] state_in;

   // Input transfers are taken only between items.
   assign req_stall    = (state_ff != wrm_pkg::ST_IDLE);
   assign cmd.op       = state_ff;
   assign cmd.accept   = (state_ff == wrm_pkg::ST_IDLE) && req_valid;
   assign cmd.load_rsp = (state_ff == wrm_pkg::ST_RESP) && status.out_free;

   // Next step.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wrm_pkg::ST_CLR: begin
            if (status.clr_last) state_in = wrm_pkg::ST_IDLE;
         end
         wrm_pkg::ST_IDLE: begin
            if (req_valid) state_in = wrm_pkg::ST_LA;
         end
         wrm_pkg::ST_LA: begin
            if (status.action == wrm_pkg::ACT_FINISH) begin
               state_in = wrm_pkg::ST_F0;
            end else if (status.la_zero) begin
               state_in = (status.action == wrm_pkg::ACT_PIXEL) ?
                          wrm_pkg::ST_IDLE : wrm_pkg::ST_RESP;
            end else if (status.action == wrm_pkg::ACT_PIXEL) begin
               state_in = wrm_pkg::ST_PIX1;
            end else if (status.action == wrm_pkg::ACT_EDGE) begin
               state_in = wrm_pkg::ST_EA1;
            end else begin
               state_in = wrm_pkg::ST_L1;
            end
         end
         wrm_pkg::ST_PIX1: begin
            state_in = status.lab_zero ? wrm_pkg::ST_IDLE : wrm_pkg::ST_PIX2;
         end
         wrm_pkg::ST_PIX2: state_in = wrm_pkg::ST_IDLE;
         wrm_pkg::ST_EA1: begin
            state_in = status.lab_zero ? wrm_pkg::ST_RESP : wrm_pkg::ST_WALKA;
         end
         wrm_pkg::ST_WALKA: begin
            if (!status.walk_more)
               state_in = status.lb_zero ? wrm_pkg::ST_RESP : wrm_pkg::ST_EB1;
         end
         wrm_pkg::ST_EB1: begin
            state_in = status.lab_zero ? wrm_pkg::ST_RESP : wrm_pkg::ST_WALKB;
         end
         wrm_pkg::ST_WALKB: begin
            if (!status.walk_more)
               state_in = status.no_merge ? wrm_pkg::ST_RESP : wrm_pkg::ST_M1;
         end
         wrm_pkg::ST_M1: state_in = wrm_pkg::ST_M2;
         wrm_pkg::ST_M2: state_in = wrm_pkg::ST_RESP;
         wrm_pkg::ST_F0: begin
            state_in = status.nc_zero ? wrm_pkg::ST_RESP : wrm_pkg::ST_F1;
         end
         wrm_pkg::ST_F1: begin
            if (status.scan_last) state_in = wrm_pkg::ST_RESP;
         end
         wrm_pkg::ST_L1: begin
            state_in = status.lab_zero ? wrm_pkg::ST_RESP : wrm_pkg::ST_WALKL;
         end
         wrm_pkg::ST_WALKL: begin
            if (!status.walk_more) state_in = wrm_pkg::ST_RESP;
         end
         wrm_pkg::ST_RESP: begin
            if (status.out_free) state_in = wrm_pkg::ST_IDLE;
         end
         default: state_in = wrm_pkg::ST_IDLE;
      endcase
   end

   // State register; reset starts the label area clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wrm_pkg::ST_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/wrm_datapath.sv
// Datapath of the watershed region merge engine: label and node stores, walk and scan.
`include "assert_macros.svh"

module wrm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  wrm_pkg::req_type                    req_payload,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [wrm_pkg::CSR_BITS-1:0]        csr_wdata,
   input  wrm_pkg::cmd_type                    cmd,
   output wrm_pkg::status_type                 status,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output wrm_pkg::rsp_type                    rsp_payload
);

   localparam int LB = wrm_pkg::LABEL_BITS;
   localparam int NB = wrm_pkg::NODE_BITS;
   localparam int CB = wrm_pkg::CNT_BITS;
   localparam int AB = wrm_pkg::AREA_BITS;
   localparam int RB = wrm_pkg::REG_BITS;

   // Stores.
   logic [AB-1:0] lab_area_mem [wrm_pkg::MAX_LABELS];
   logic [NB-1:0] lab_leaf_mem [wrm_pkg::MAX_LABELS];
   logic [CB-1:0] node_parent_mem [wrm_pkg::MAX_NODES];
   logic [AB-1:0] node_area_mem [wrm_pkg::MAX_NODES];
   logic [RB-1:0] node_region_mem [wrm_pkg::MAX_NODES];

   logic [AB-1:0] lab_area_q;
   logic [NB-1:0] lab_leaf_q;
   logic [CB-1:0] parent_q;
   logic [AB-1:0] area_q;
   logic [RB-1:0] region_q;

   // Registers.
   wrm_pkg::req_type   req_ff;
   wrm_pkg::rsp_type   res_ff;
   wrm_pkg::rsp_type   rsp_ff;
   logic               rsp_valid_ff;
   logic signed [15:0] thr_ff;
   logic [AB-1:0]      min_ff;
   logic [CB-1:0]      nc_ff;
   logic [LB-1:0]      clr_ff;
   logic [NB-1:0]      cur_ff;
   logic [NB-1:0]      r0_ff;
   logic [AB-1:0]      a0_ff;
   logic [NB-1:0]      scan_ff;
   logic [RB-1:0]      tot_ff;

   // Combinational helpers.
   logic [LB-1:0] lab_raddr;
   logic [NB-1:0] node_raddr;
   logic          walk_more;
   logic          lab_zero;
   logic          full;
   logic          no_merge;
   logic [AB:0]   sum;
   logic [AB-1:0] sum_sat;
   logic [AB-1:0] lab_inc;
   logic [AB-1:0] node_inc;
   logic [RB-1:0] tot_next;
   logic          scan_last;
   logic          new_leaf;
   logic          do_make;

   logic          lab_area_we;
   logic [LB-1:0] lab_area_wa;
   logic [AB-1:0] lab_area_wd;
   logic          lab_leaf_we;
   logic          par_we;
   logic [NB-1:0] par_wa;
   logic [CB-1:0] par_wd;
   logic          area_we;
   logic [NB-1:0] area_wa;
   logic [AB-1:0] area_wd;
   logic          reg_we;
   logic [NB-1:0] reg_wa;
   logic [RB-1:0] reg_wd;

   // Decisions on the registered read data.
   always_comb begin
      walk_more = parent_q < nc_ff;
      lab_zero  = (lab_area_q == '0);
      full      = nc_ff >= CB'(wrm_pkg::MAX_NODES);
      no_merge  = ((req_ff.strength > thr_ff) && (area_q >= min_ff) && (a0_ff >= min_ff))
                  || (r0_ff == cur_ff) || full;
      sum       = {1'b0, a0_ff} + {1'b0, area_q};
      sum_sat   = sum[AB] ? wrm_pkg::AREA_MAX : sum[AB-1:0];
      lab_inc   = (lab_area_q == wrm_pkg::AREA_MAX) ? lab_area_q : lab_area_q + 1'b1;
      node_inc  = (area_q == wrm_pkg::AREA_MAX) ? area_q : area_q + 1'b1;
      tot_next  = ((parent_q >= nc_ff) && (tot_ff != wrm_pkg::REGION_MAX)) ?
                  tot_ff + 1'b1 : tot_ff;
      scan_last = ({1'b0, scan_ff} + 1'b1) >= nc_ff;
      new_leaf  = (cmd.op == wrm_pkg::ST_PIX1) && lab_zero && !full;
      do_make   = (cmd.op == wrm_pkg::ST_WALKB) && !walk_more && !no_merge;
   end

   // Read addresses.
   always_comb begin
      lab_raddr = (cmd.op == wrm_pkg::ST_WALKA) ? req_ff.label_b : req_ff.label_a;
      case (cmd.op)
         wrm_pkg::ST_WALKA, wrm_pkg::ST_WALKB, wrm_pkg::ST_WALKL:
            node_raddr = parent_q[NB-1:0];
         wrm_pkg::ST_F0: node_raddr = '0;
         wrm_pkg::ST_F1: node_raddr = scan_ff + 1'b1;
         default:        node_raddr = lab_leaf_q;
      endcase
   end

   // Write ports.
   always_comb begin
      lab_area_we = 1'b0;
      lab_area_wa = req_ff.label_a;
      lab_area_wd = lab_inc;
      lab_leaf_we = new_leaf;
      if (cmd.op == wrm_pkg::ST_CLR) begin
         lab_area_we = 1'b1;
         lab_area_wa = clr_ff;
         lab_area_wd = '0;
      end else if (cmd.op == wrm_pkg::ST_PIX1) begin
         lab_area_we = new_leaf || !lab_zero;
         lab_area_wd = lab_zero ? AB'(1) : lab_inc;
      end

      par_we = new_leaf || do_make;
      par_wa = nc_ff[NB-1:0];
      par_wd = wrm_pkg::NO_PARENT;
      if (cmd.op == wrm_pkg::ST_M1) begin
         par_we = 1'b1;
         par_wa = r0_ff;
         par_wd = nc_ff;
      end else if (cmd.op == wrm_pkg::ST_M2) begin
         par_we = 1'b1;
         par_wa = cur_ff;
         par_wd = nc_ff;
      end

      area_we = new_leaf || do_make || (cmd.op == wrm_pkg::ST_PIX2);
      area_wa = (cmd.op == wrm_pkg::ST_PIX2) ? cur_ff : nc_ff[NB-1:0];
      area_wd = (cmd.op == wrm_pkg::ST_PIX2) ? node_inc :
                (do_make ? sum_sat : AB'(1));

      reg_we = new_leaf || do_make;
      reg_wa = nc_ff[NB-1:0];
      reg_wd = '0;
      if ((cmd.op == wrm_pkg::ST_F1) && (parent_q >= nc_ff)) begin
         reg_we = 1'b1;
         reg_wa = scan_ff;
         reg_wd = tot_next;
      end
   end

   // Label store.
   always_ff @(posedge clock) begin
      if (lab_area_we) lab_area_mem[lab_area_wa] <= lab_area_wd;
      if (lab_leaf_we) lab_leaf_mem[req_ff.label_a] <= nc_ff[NB-1:0];
      lab_area_q <= lab_area_mem[lab_raddr];
      lab_leaf_q <= lab_leaf_mem[lab_raddr];
   end

   // Node store.
   always_ff @(posedge clock) begin
      if (par_we)  node_parent_mem[par_wa] <= par_wd;
      if (area_we) node_area_mem[area_wa] <= area_wd;
      if (reg_we)  node_region_mem[reg_wa] <= reg_wd;
      parent_q <= node_parent_mem[node_raddr];
      area_q   <= node_area_mem[node_raddr];
      region_q <= node_region_mem[node_raddr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= '0;
         min_ff       <= '0;
         nc_ff        <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && (csr_index == wrm_pkg::CSR_THRESHOLD)) thr_ff <= $signed(csr_wdata[15:0]);
         if (csr_we && (csr_index == wrm_pkg::CSR_MIN_AREA))  min_ff <= csr_wdata[AB-1:0];
         if (cmd.op == wrm_pkg::ST_CLR) clr_ff <= clr_ff + 1'b1;
         if (new_leaf || (cmd.op == wrm_pkg::ST_M2)) nc_ff <= nc_ff + 1'b1;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers and the pending result.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_payload;
         res_ff <= '0;
      end
      case (cmd.op)
         wrm_pkg::ST_PIX1, wrm_pkg::ST_EA1, wrm_pkg::ST_EB1, wrm_pkg::ST_L1: begin
            cur_ff <= lab_leaf_q;
         end
         wrm_pkg::ST_WALKA: begin
            if (walk_more) begin
               cur_ff <= parent_q[NB-1:0];
            end else begin
               r0_ff <= cur_ff;
               a0_ff <= area_q;
            end
         end
         wrm_pkg::ST_WALKB: begin
            if (walk_more) cur_ff <= parent_q[NB-1:0];
         end
         wrm_pkg::ST_WALKL: begin
            if (walk_more) begin
               cur_ff <= parent_q[NB-1:0];
            end else begin
               res_ff.region_number <= region_q;
            end
         end
         wrm_pkg::ST_M2: begin
            res_ff.merged   <= 1'b1;
            res_ff.new_node <= nc_ff[NB-1:0];
         end
         wrm_pkg::ST_F0: begin
            scan_ff <= '0;
            tot_ff  <= '0;
         end
         wrm_pkg::ST_F1: begin
            tot_ff  <= tot_next;
            scan_ff <= scan_ff + 1'b1;
            if (scan_last) res_ff.region_total <= tot_next;
         end
         default: begin
         end
      endcase
      if (cmd.load_rsp) rsp_ff <= res_ff;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Status to the controller.
   assign status.action    = req_ff.action;
   assign status.la_zero   = (req_ff.label_a == '0);
   assign status.lb_zero   = (req_ff.label_b == '0);
   assign status.lab_zero  = lab_zero;
   assign status.walk_more = walk_more;
   assign status.no_merge  = no_merge;
   assign status.nc_zero   = (nc_ff == '0);
   assign status.scan_last = scan_last;
   assign status.clr_last  = &clr_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // Checks.
   `ASSERT_HOLDS(a_nc_bound, clock, reset, nc_ff <= CB'(wrm_pkg::MAX_NODES), "node count overflow")
   `ASSERT_HOLDS(a_merge_distinct, clock, reset, (cmd.op == wrm_pkg::ST_M2) |-> (r0_ff != cur_ff), "merge of one root with itself")
   `ASSERT_HOLDS(a_scan_range, clock, reset, (cmd.op == wrm_pkg::ST_F1) |-> ({1'b0, scan_ff} < nc_ff), "scan beyond node count")
   `ASSERT_NEVER(a_load_busy, clock, reset, cmd.load_rsp && rsp_valid_ff && rsp_stall, "result overwritten while stalled")

endmodule

FILE: dv/tb_watershed_region_merge_min_area.sv
// Self-checking testbench for the watershed region merge engine.
`timescale 1ns / 1ps

module tb_watershed_region_merge_min_area;

   localparam int CYCLE_LIMIT = 20000000;
   localparam int ITEM_GOAL   = 1950;

   localparam int LBITS = wrm_pkg::LABEL_BITS;
   localparam int NBITS = wrm_pkg::NODE_BITS;
   localparam int CBITS = wrm_pkg::CNT_BITS;
   localparam int ABITS = wrm_pkg::AREA_BITS;
   localparam int RBITS = wrm_pkg::REG_BITS;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   wrm_pkg::req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   wrm_pkg::rsp_type rsp_payload;
   logic    csr_we;
   logic    csr_index;
   logic [wrm_pkg::CSR_BITS-1:0] csr_wdata;

   watershed_region_merge_min_area i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // Shadow copy of the merge forest and the configuration.
   logic signed [15:0]    thr_q;
   logic [ABITS-1:0]      min_area_q;
   logic [ABITS-1:0]      lab_area [wrm_pkg::MAX_LABELS];
   logic [NBITS-1:0]      lab_leaf [wrm_pkg::MAX_LABELS];
   logic [CBITS-1:0]      nd_parent [wrm_pkg::MAX_NODES];
   logic [ABITS-1:0]      nd_area [wrm_pkg::MAX_NODES];
   logic [RBITS-1:0]      nd_region [wrm_pkg::MAX_NODES];
   logic [CBITS-1:0]      nodes_used;

   wrm_pkg::rsp_type expected_rsps[$];
   int      error_count;
   int      cycle_count;
   bit      quiet;
   int      items_sent;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report(input string what);
      error_count++;
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
   endtask

   function automatic bit label_has_leaf(input logic [LBITS-1:0] lab);
      return lab != 0 && lab_area[lab] != 0 && CBITS'(lab_leaf[lab]) < nodes_used;
   endfunction

   function automatic logic [CBITS-1:0] find_root(input logic [CBITS-1:0] start);
      logic [CBITS-1:0] n;
      int steps;
      n = start;
      steps = 0;
      while (n < nodes_used && nd_parent[n[NBITS-1:0]] < nodes_used
             && steps < wrm_pkg::MAX_NODES) begin
         n = nd_parent[n[NBITS-1:0]];
         steps++;
      end
      return n;
   endfunction

   // Advance the shadow forest by one item; returns 1 when a result is due.
   function automatic bit merge_forest_step(input wrm_pkg::req_type r,
                                            output wrm_pkg::rsp_type o);
      logic [CBITS-1:0] r0, r1;
      logic [ABITS:0]   sum;
      logic [RBITS-1:0] n;
      bit big;
      o = '0;
      case (r.action)
         wrm_pkg::ACT_PIXEL: begin
            if (r.label_a == 0) return 0;
            if (lab_area[r.label_a] == 0) begin
               if (nodes_used >= wrm_pkg::MAX_NODES) return 0;
               lab_leaf[r.label_a] = nodes_used[NBITS-1:0];
               nd_parent[nodes_used[NBITS-1:0]] = wrm_pkg::NO_PARENT;
               nd_area[nodes_used[NBITS-1:0]] = '0;
               nd_region[nodes_used[NBITS-1:0]] = '0;
               nodes_used++;
            end
            if (lab_area[r.label_a] != wrm_pkg::AREA_MAX) lab_area[r.label_a]++;
            if (nd_area[lab_leaf[r.label_a]] != wrm_pkg::AREA_MAX)
               nd_area[lab_leaf[r.label_a]]++;
            return 0;
         end
         wrm_pkg::ACT_EDGE: begin
            if (!label_has_leaf(r.label_a) || !label_has_leaf(r.label_b)) return 1;
            r0 = find_root(CBITS'(lab_leaf[r.label_a]));
            r1 = find_root(CBITS'(lab_leaf[r.label_b]));
            if (r0 >= nodes_used || r1 >= nodes_used) return 1;
            big = nd_area[r0[NBITS-1:0]] >= min_area_q
                  && nd_area[r1[NBITS-1:0]] >= min_area_q;
            if (r.strength > thr_q && big) return 1;
            if (r0 == r1 || nodes_used >= wrm_pkg::MAX_NODES) return 1;
            sum = nd_area[r0[NBITS-1:0]] + nd_area[r1[NBITS-1:0]];
            if (sum > wrm_pkg::AREA_MAX) sum = {1'b0, wrm_pkg::AREA_MAX};
            nd_parent[nodes_used[NBITS-1:0]] = wrm_pkg::NO_PARENT;
            nd_area[nodes_used[NBITS-1:0]] = sum[ABITS-1:0];
            nd_region[nodes_used[NBITS-1:0]] = '0;
            nd_parent[r0[NBITS-1:0]] = nodes_used;
            nd_parent[r1[NBITS-1:0]] = nodes_used;
            o.merged = 1'b1;
            o.new_node = nodes_used[NBITS-1:0];
            nodes_used++;
            return 1;
         end
         wrm_pkg::ACT_FINISH: begin
            n = '0;
            for (int i = 0; i < nodes_used; i++) begin
               if (nd_parent[i] >= nodes_used) begin
                  if (n != wrm_pkg::REGION_MAX) n++;
                  nd_region[i] = n;
               end
            end
            o.region_total = n;
            return 1;
         end
         default: begin
            if (label_has_leaf(r.label_a)) begin
               r0 = find_root(CBITS'(lab_leaf[r.label_a]));
               if (r0 < nodes_used) o.region_number = nd_region[r0[NBITS-1:0]];
            end
            return 1;
         end
      endcase
   endfunction

   // Offer one item and wait for its transfer; optionally override the expectation.
   task automatic send_item(input wrm_pkg::req_type r, input bit typed,
                            input wrm_pkg::rsp_type typed_rsp);
      wrm_pkg::rsp_type o;
      bit due;
      while (!quiet && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      due = merge_forest_step(r, o);
      if (typed) o = typed_rsp;
      if (due) expected_rsps.push_back(o);
      items_sent++;
   endtask

   // Let the engine drain, then write one register.
   task automatic write_csr(input logic idx, input logic [wrm_pkg::CSR_BITS-1:0] val);
      req_valid <= 1'b0;
      wait (expected_rsps.size() == 0);
      repeat (12) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == wrm_pkg::CSR_THRESHOLD) thr_q = val[15:0];
      else min_area_q = val;
   endtask

   function automatic wrm_pkg::req_type make_req(input logic [1:0] act, input int la,
                                                 input int lb, input int s);
      wrm_pkg::req_type r;
      r.action = act;
      r.label_a = la[LBITS-1:0];
      r.label_b = lb[LBITS-1:0];
      r.strength = s[15:0];
      return r;
   endfunction

   // Result channel: random stall and comparison against the oldest expectation.
   always @(posedge clock) begin
      wrm_pkg::rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 29);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report("result transfer with nothing expected");
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_payload.merged !== e.merged)
                  report($sformatf("merged %0b, wanted %0b", rsp_payload.merged, e.merged));
               if (rsp_payload.new_node !== e.new_node)
                  report($sformatf("new_node %0d, wanted %0d",
                                   rsp_payload.new_node, e.new_node));
               if (rsp_payload.region_number !== e.region_number)
                  report($sformatf("region_number %0d, wanted %0d",
                                   rsp_payload.region_number, e.region_number));
               if (rsp_payload.region_total !== e.region_total)
                  report($sformatf("region_total %0d, wanted %0d",
                                   rsp_payload.region_total, e.region_total));
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   typedef struct {
      wrm_pkg::req_type r;
      bit               typed;
      wrm_pkg::rsp_type o;
   } directed_row_type;

   initial begin
      directed_row_type rows[$];
      int labs[$];
      int s, n_edges, la, lb, phase;
      wrm_pkg::rsp_type none;
      none = '0;
      error_count = 0;
      cycle_count = 0;
      items_sent = 0;
      quiet = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = wrm_pkg::CSR_THRESHOLD;
      csr_wdata = '0;
      thr_q = '0;
      min_area_q = '0;
      nodes_used = '0;
      foreach (lab_area[i]) lab_area[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty forest, boundary labels, extremes, unnumbered roots.
      rows.push_back('{make_req(wrm_pkg::ACT_LOOKUP, 5, 1023, -1), 1, none});
      rows.push_back('{make_req(wrm_pkg::ACT_FINISH, 1023, 1023, 32767), 1, none});
      rows.push_back('{make_req(wrm_pkg::ACT_PIXEL, 0, 0, 0), 0, none});
      rows.push_back('{make_req(wrm_pkg::ACT_PIXEL, 1023, 0, 0), 0, none});
      rows.push_back('{make_req(wrm_pkg::ACT_PIXEL, 1, 0, 0), 0, none});
      rows.push_back('{make_req(wrm_pkg::ACT_PIXEL, 1, 1023, -32768), 0, none});
      rows.push_back('{make_req(wrm_pkg::ACT_PIXEL, 2, 0, 0), 0, none});
      rows.push_back('{make_req(wrm_pkg::ACT_EDGE, 0, 1, -32768), 1, none});
      rows.push_back('{make_req(wrm_pkg::ACT_EDGE, 1, 1000, -32768), 1, none});
      rows.push_back('{make_req(wrm_pkg::ACT_EDGE, 1, 2, 32767), 1, none});
      rows.push_back('{make_req(wrm_pkg::ACT_EDGE, 1, 1023, -32768), 0, none});
      rows.push_back('{make_req(wrm_pkg::ACT_EDGE, 1023, 1, -32768), 1, none});
      rows.push_back('{make_req(wrm_pkg::ACT_EDGE, 2, 1, 0), 0, none});
      rows.push_back('{make_req(wrm_pkg::ACT_FINISH, 0, 0, 0), 0, none});
      rows.push_back('{make_req(wrm_pkg::ACT_LOOKUP, 0, 0, 0), 1, none});
      rows.push_back('{make_req(wrm_pkg::ACT_LOOKUP, 1023, 0, 0), 0, none});
      rows.push_back('{make_req(wrm_pkg::ACT_LOOKUP, 1000, 0, 0), 1, none});
      rows.push_back('{make_req(wrm_pkg::ACT_PIXEL, 3, 0, 0), 0, none});
      rows.push_back('{make_req(wrm_pkg::ACT_EDGE, 3, 2, -32768), 0, none});
      rows.push_back('{make_req(wrm_pkg::ACT_LOOKUP, 3, 1023, 32767), 0, none});
      rows.push_back('{make_req(wrm_pkg::ACT_PIXEL, 4, 0, 0), 0, none});
      rows.push_back('{make_req(wrm_pkg::ACT_LOOKUP, 4, 0, 0), 1, none});
      foreach (rows[i]) send_item(rows[i].r, rows[i].typed, rows[i].o);

      // Random phases, each under its own register setting.
      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         case (phase % 6)
            0: write_csr(wrm_pkg::CSR_THRESHOLD, {4'hF, 16'h8000});
            1: write_csr(wrm_pkg::CSR_THRESHOLD, {4'h0, 16'h7FFF});
            default: write_csr(wrm_pkg::CSR_THRESHOLD, wrm_pkg::CSR_BITS'($urandom()));
         endcase
         case (phase % 5)
            0: write_csr(wrm_pkg::CSR_MIN_AREA, '1);
            1: write_csr(wrm_pkg::CSR_MIN_AREA, '0);
            default: write_csr(wrm_pkg::CSR_MIN_AREA,
                               wrm_pkg::CSR_BITS'($urandom_range(8, 1)));
         endcase
         quiet = (phase == 3);
         labs.delete();
         repeat ($urandom_range(40, 15)) labs.push_back($urandom_range(1023, 1));
         // Pixels for the phase's labels, with some boundary noise.
         repeat (labs.size() * 3) begin
            if ($urandom_range(9) == 0) la = 0;
            else la = labs[$urandom_range(labs.size() - 1)];
            send_item(make_req(wrm_pkg::ACT_PIXEL, la, $urandom(), $urandom()), 0, none);
         end
         // Edges in ascending strength, some noise items mixed in.
         s = $urandom_range(65535) - 65536 + ($urandom_range(1) ? 32768 : 0);
         n_edges = labs.size() * 3;
         for (int k = 0; k < n_edges; k++) begin
            if (s < -32768) s = -32768;
            if (s > 32767) s = 32767;
            la = labs[$urandom_range(labs.size() - 1)];
            lb = labs[$urandom_range(labs.size() - 1)];
            if ($urandom_range(9) == 0) begin
               send_item(make_req(2'($urandom_range(3)), $urandom(), $urandom(),
                                  $urandom()), 0, none);
            end else begin
               send_item(make_req(wrm_pkg::ACT_EDGE, la, lb, s), 0, none);
            end
            s += $urandom_range(700);
         end
         send_item(make_req(wrm_pkg::ACT_FINISH, $urandom(), $urandom(), $urandom()),
                   0, none);
         repeat (labs.size()) begin
            la = ($urandom_range(7) == 0) ? $urandom_range(1023)
                                          : labs[$urandom_range(labs.size() - 1)];
            send_item(make_req(wrm_pkg::ACT_LOOKUP, la, $urandom(), $urandom()), 0, none);
         end
         phase++;
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      // Drain and let any trailing pixel work settle.
      wait (expected_rsps.size() == 0);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
